// File: sv/ddsr_pkg.sv
// Shared types, constants and the control-store program of the soft-start ramp unit.
package ddsr_pkg;

  // Field widths fixed by the interface
  localparam int FUNC_W     = 2;
  localparam int DAC_W      = 16;
  localparam int NOW_W      = 32;
  localparam int DUR_W      = 20;
  localparam int CMD_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Parameter defaults and limits
  localparam int CODE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int CODE_MAX      = 24;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_V = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_C = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_V_DUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_DUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_CMD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C_CMD = 2'd3;

  // Register reset values
  localparam logic [DUR_W-1:0] DUR_RST   = 20'd2000;
  localparam logic [CMD_W-1:0] V_CMD_RST = 8'b0010_0100;
  localparam logic [CMD_W-1:0] C_CMD_RST = 8'b0001_0000;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_SET,
    OP_SEL_V,
    OP_SEL_C,
    OP_ELAP,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_FIN,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_IS_TICK,
    C_IS_BAD,
    C_CH_OFF,
    C_DONE,
    C_DIV_MORE,
    C_OUT_BUSY,
    C_LAST_CH
  } cond_t;

  localparam int PC_W = 4;

  // Program addresses
  localparam logic [PC_W-1:0] A_FETCH = 4'd0;
  localparam logic [PC_W-1:0] A_DISP  = 4'd1;
  localparam logic [PC_W-1:0] A_CHKF  = 4'd2;
  localparam logic [PC_W-1:0] A_SET   = 4'd3;
  localparam logic [PC_W-1:0] A_SELV  = 4'd4;
  localparam logic [PC_W-1:0] A_CHK   = 4'd5;
  localparam logic [PC_W-1:0] A_ELAP  = 4'd6;
  localparam logic [PC_W-1:0] A_MUL   = 4'd7;
  localparam logic [PC_W-1:0] A_DIVI  = 4'd8;
  localparam logic [PC_W-1:0] A_DIVS  = 4'd9;
  localparam logic [PC_W-1:0] A_DIVD  = 4'd10;
  localparam logic [PC_W-1:0] A_FIN   = 4'd11;
  localparam logic [PC_W-1:0] A_EMIT  = 4'd12;
  localparam logic [PC_W-1:0] A_NEXT  = 4'd13;
  localparam logic [PC_W-1:0] A_SELC  = 4'd14;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } ucode_t;

  // Datapath flags tested by the sequencer
  typedef struct packed {
    logic no_in;
    logic is_tick;
    logic is_bad;
    logic ch_off;
    logic done;
    logic div_more;
    logic out_busy;
    logic last_ch;
  } status_t;

  // Control store: jump to tgt when cond holds, else fall through
  function automatic ucode_t ucode(input logic [PC_W-1:0] a);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, tgt: A_FETCH};
    case (a)
      A_FETCH: w = '{op: OP_FETCH,    cond: C_NO_IN,    tgt: A_FETCH};
      A_DISP:  w = '{op: OP_NOP,      cond: C_IS_TICK,  tgt: A_SELV};
      A_CHKF:  w = '{op: OP_NOP,      cond: C_IS_BAD,   tgt: A_FETCH};
      A_SET:   w = '{op: OP_SET,      cond: C_ALWAYS,   tgt: A_EMIT};
      A_SELV:  w = '{op: OP_SEL_V,    cond: C_NONE,     tgt: A_FETCH};
      A_CHK:   w = '{op: OP_NOP,      cond: C_CH_OFF,   tgt: A_NEXT};
      A_ELAP:  w = '{op: OP_ELAP,     cond: C_NONE,     tgt: A_FETCH};
      A_MUL:   w = '{op: OP_MUL,      cond: C_DONE,     tgt: A_FIN};
      A_DIVI:  w = '{op: OP_DIV_INIT, cond: C_NONE,     tgt: A_FETCH};
      A_DIVS:  w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, tgt: A_DIVS};
      A_DIVD:  w = '{op: OP_DIV_DONE, cond: C_ALWAYS,   tgt: A_EMIT};
      A_FIN:   w = '{op: OP_FIN,      cond: C_NONE,     tgt: A_FETCH};
      A_EMIT:  w = '{op: OP_EMIT,     cond: C_OUT_BUSY, tgt: A_EMIT};
      A_NEXT:  w = '{op: OP_NOP,      cond: C_LAST_CH,  tgt: A_FETCH};
      A_SELC:  w = '{op: OP_SEL_C,    cond: C_ALWAYS,   tgt: A_CHK};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,   tgt: A_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: sv/dual_dac_soft_start_ramp_unit.sv
// Top level of the two-channel DAC soft-start ramp unit.
//
// Input channel (in_valid/in_ready): one item per set-point write or time tick.
//   func 1/2 sets the voltage/current code, optionally starting a linear ramp;
//   func 0 is a tick that emits the ramp value of each active channel,
//   voltage first; func 3 is dropped without a frame.
// Output channel (out_valid/out_ready): 24-bit DAC frames (command byte + code),
//   out_last_of_run marks the final frame of an item.
// Config port (cfg_we/cfg_idx/cfg_wdata): ramp durations and buffer command
//   bytes; the user must write them only while the unit is idle (not enforced).
// Control is a 15-step microprogram; in_ready is high only in its fetch step.
// Sequencing: a set item is emitted straight after its state update. A tick
//   checks each channel in turn; an idle one is skipped, one whose ramp has run
//   out emits its target, and a ramping one runs through the one-bit-per-cycle
//   restoring divider that forms target*elapsed/duration; one item is in work
//   at a time.
// Reset: durations 2000 us, command bytes 0x24/0x10, both ramps off,
//   output register empty; no clearing pass.
// Stall: a frame sits in the output register until taken; the program holds
//   in its emit step while the register is still full, so in_ready stays low.
module dual_dac_soft_start_ramp_unit #(
  parameter int CODE_BITS = ddsr_pkg::CODE_BITS_DEF,
  parameter int TIME_BITS = ddsr_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ddsr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ddsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ddsr_pkg::FUNC_W-1:0]     in_func,
  input  logic [ddsr_pkg::DAC_W-1:0]      in_dac_code,
  input  logic                            in_ramp_req,
  input  logic                            in_external_ramp_active,
  input  logic [ddsr_pkg::NOW_W-1:0]      in_now_usec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ddsr_pkg::CMD_W-1:0]      out_command_byte,
  output logic [ddsr_pkg::DAC_W-1:0]      out_code_out,
  output logic                            out_last_of_run
);

  ddsr_pkg::ucode_t  ctrl;   // current control word
  ddsr_pkg::status_t stat;   // flags for conditional jumps

  ddsr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ddsr_datapath #(
    .CODE_BITS (CODE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctrl                    (ctrl),
    .stat                    (stat),
    .cfg_we                  (cfg_we),
    .cfg_idx                 (cfg_idx),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_func                 (in_func),
    .in_dac_code             (in_dac_code),
    .in_ramp_req             (in_ramp_req),
    .in_external_ramp_active (in_external_ramp_active),
    .in_now_usec             (in_now_usec),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_command_byte        (out_command_byte),
    .out_code_out            (out_code_out),
    .out_last_of_run         (out_last_of_run)
  );

  // after taking an item the program must leave the fetch step
  a_fetch_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("fetch step held after item accepted");

  // with no item offered the program waits in fetch
  a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("fetch step left without an item");

  // an emit with a free output register must produce a frame
  a_emit_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == ddsr_pkg::OP_EMIT && !stat.out_busy |=> out_valid)
    else $error("emit step did not load the output register");

  // the divider never runs while an item is being fetched
  a_div_not_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == ddsr_pkg::OP_DIV_STEP |-> !in_ready)
    else $error("divider step overlaps fetch");

endmodule

// File: sv/ddsr_seq.sv
// Step counter and control store of the ramp unit sequencer.
module ddsr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ddsr_pkg::status_t stat,
  output ddsr_pkg::ucode_t  ctrl
);

  logic [ddsr_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      take;

  assign ctrl = ddsr_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      ddsr_pkg::C_NONE:     take = 1'b0;
      ddsr_pkg::C_ALWAYS:   take = 1'b1;
      ddsr_pkg::C_NO_IN:    take = stat.no_in;
      ddsr_pkg::C_IS_TICK:  take = stat.is_tick;
      ddsr_pkg::C_IS_BAD:   take = stat.is_bad;
      ddsr_pkg::C_CH_OFF:   take = stat.ch_off;
      ddsr_pkg::C_DONE:     take = stat.done;
      ddsr_pkg::C_DIV_MORE: take = stat.div_more;
      ddsr_pkg::C_OUT_BUSY: take = stat.out_busy;
      ddsr_pkg::C_LAST_CH:  take = stat.last_ch;
      default:              take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.tgt : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ddsr_pkg::A_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/ddsr_datapath.sv
// Ramp unit datapath: registers, channel state, multiplier, serial divider, output stage.
module ddsr_datapath #(
  parameter int CODE_BITS = ddsr_pkg::CODE_BITS_DEF,
  parameter int TIME_BITS = ddsr_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ddsr_pkg::ucode_t                ctrl,
  output ddsr_pkg::status_t               stat,
  input  logic                            cfg_we,
  input  logic [ddsr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ddsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ddsr_pkg::FUNC_W-1:0]     in_func,
  input  logic [ddsr_pkg::DAC_W-1:0]      in_dac_code,
  input  logic                            in_ramp_req,
  input  logic                            in_external_ramp_active,
  input  logic [ddsr_pkg::NOW_W-1:0]      in_now_usec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ddsr_pkg::CMD_W-1:0]      out_command_byte,
  output logic [ddsr_pkg::DAC_W-1:0]      out_code_out,
  output logic                            out_last_of_run
);

  localparam int DUR_W  = ddsr_pkg::DUR_W;
  localparam int CMD_W  = ddsr_pkg::CMD_W;
  localparam int CMP_W  = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam int PROD_W = CODE_BITS + DUR_W;
  localparam int CNT_W  = $clog2(CODE_BITS);

  // configuration
  logic [DUR_W-1:0] v_dur_r, c_dur_r;
  logic [CMD_W-1:0] v_cmd_r, c_cmd_r;

  // latched item
  logic [ddsr_pkg::FUNC_W-1:0] func_r;
  logic [CODE_BITS-1:0]        code_r;
  logic                        ramp_r;
  logic [TIME_BITS-1:0]        now_r;

  // per-channel ramp state, index 0 voltage, 1 current
  logic [1:0]           on_r;
  logic [CODE_BITS-1:0] tgt_r   [2];
  logic [TIME_BITS-1:0] start_r [2];

  // working registers
  logic                 ch_r;
  logic [TIME_BITS-1:0] elap_r;
  logic [PROD_W-1:0]    prod_r;
  logic [DUR_W-1:0]     rem_r;
  logic [CODE_BITS-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CODE_BITS-1:0] res_r;

  logic                      out_valid_r;
  logic [CMD_W-1:0]          out_cmd_r;
  logic [ddsr_pkg::DAC_W-1:0] out_code_r;
  logic                      out_last_r;

  logic [ddsr_pkg::CODE_MAX-1:0] code_wide, res_wide;
  logic [DUR_W-1:0]              dur_sel;
  logic [CODE_BITS-1:0]          tgt_sel;
  logic [CMP_W-1:0]              elap_ext, dur_ext;
  logic [DUR_W:0]                trial, trial_sub;
  logic                          ge;
  logic                          set_ch;
  logic                          out_free;

  assign code_wide = ddsr_pkg::CODE_MAX'(in_dac_code);
  assign res_wide  = ddsr_pkg::CODE_MAX'(res_r);
  assign dur_sel   = ch_r ? c_dur_r : v_dur_r;
  assign tgt_sel   = tgt_r[ch_r];
  assign elap_ext  = CMP_W'(elap_r);
  assign dur_ext   = CMP_W'(dur_sel);
  assign set_ch    = (func_r == ddsr_pkg::FUNC_SET_C);

  // restoring divide step
  assign trial     = {rem_r, quo_r[CODE_BITS-1]};
  assign trial_sub = trial - {1'b0, dur_sel};
  assign ge        = (trial >= {1'b0, dur_sel});

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (ctrl.op == ddsr_pkg::OP_FETCH);

  always_comb begin
    stat.no_in    = !in_valid;
    stat.is_tick  = (func_r == ddsr_pkg::FUNC_TICK);
    stat.is_bad   = !(func_r inside {ddsr_pkg::FUNC_TICK, ddsr_pkg::FUNC_SET_V,
                                     ddsr_pkg::FUNC_SET_C});
    stat.ch_off   = !on_r[ch_r];
    stat.done     = (elap_ext >= dur_ext);
    stat.div_more = (cnt_r != '0);
    stat.out_busy = !out_free;
    stat.last_ch  = ch_r || (func_r != ddsr_pkg::FUNC_TICK);
  end

  // configuration and output handshake (control state)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_dur_r     <= ddsr_pkg::DUR_RST;
      c_dur_r     <= ddsr_pkg::DUR_RST;
      v_cmd_r     <= ddsr_pkg::V_CMD_RST;
      c_cmd_r     <= ddsr_pkg::C_CMD_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ddsr_pkg::REG_V_DUR: v_dur_r <= cfg_wdata[DUR_W-1:0];
          ddsr_pkg::REG_C_DUR: c_dur_r <= cfg_wdata[DUR_W-1:0];
          ddsr_pkg::REG_V_CMD: v_cmd_r <= cfg_wdata[CMD_W-1:0];
          ddsr_pkg::REG_C_CMD: c_cmd_r <= cfg_wdata[CMD_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.op == ddsr_pkg::OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r       <= '0;
      tgt_r[0]   <= '0;
      tgt_r[1]   <= '0;
      start_r[0] <= '0;
      start_r[1] <= '0;
    end else begin
      case (ctrl.op)
        ddsr_pkg::OP_SET: begin
          on_r[set_ch] <= ramp_r;
          if (ramp_r) begin
            tgt_r[set_ch]   <= code_r;
            start_r[set_ch] <= now_r;
          end
        end
        ddsr_pkg::OP_FIN: on_r[ch_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      ddsr_pkg::OP_FETCH: begin
        if (in_valid) begin
          func_r <= in_func;
          code_r <= code_wide[CODE_BITS-1:0];
          ramp_r <= in_ramp_req && !in_external_ramp_active;
          now_r  <= in_now_usec[TIME_BITS-1:0];
        end
      end
      ddsr_pkg::OP_SET: begin
        ch_r  <= set_ch;
        res_r <= ramp_r ? '0 : code_r;
      end
      ddsr_pkg::OP_SEL_V: ch_r <= 1'b0;
      ddsr_pkg::OP_SEL_C: ch_r <= 1'b1;
      ddsr_pkg::OP_ELAP:  elap_r <= now_r - start_r[ch_r];
      ddsr_pkg::OP_MUL:   prod_r <= PROD_W'(tgt_sel) * PROD_W'(elap_ext[DUR_W-1:0]);
      ddsr_pkg::OP_DIV_INIT: begin
        rem_r <= prod_r[PROD_W-1:CODE_BITS];
        quo_r <= prod_r[CODE_BITS-1:0];
        cnt_r <= CNT_W'(CODE_BITS - 1);
      end
      ddsr_pkg::OP_DIV_STEP: begin
        rem_r <= ge ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
        quo_r <= {quo_r[CODE_BITS-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      ddsr_pkg::OP_DIV_DONE: res_r <= quo_r;
      ddsr_pkg::OP_FIN:      res_r <= tgt_sel;
      ddsr_pkg::OP_EMIT: begin
        if (out_free) begin
          out_cmd_r  <= ch_r ? c_cmd_r : v_cmd_r;
          out_code_r <= res_wide[ddsr_pkg::DAC_W-1:0];
          out_last_r <= ch_r || (func_r != ddsr_pkg::FUNC_TICK) || !on_r[1];
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_command_byte = out_cmd_r;
  assign out_code_out     = out_code_r;
  assign out_last_of_run  = out_last_r;

endmodule
